[src/frustum_sphere_culler_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_SPHERE_CULLER_MACROS_SVH
`define FRUSTUM_SPHERE_CULLER_MACROS_SVH

// same-cycle implication
`define FSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/fsc_pkg.sv]
// ----------------------------------------------------------------------------
// fsc_pkg
// Types, codes and constants of the frustum sphere culler.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int PLANE_COUNT   = 6;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_BUILD = 2'd1;
    localparam logic [1:0] ACT_TEST  = 2'd2;

    localparam logic REPLY_BUILT = 1'b0;
    localparam logic REPLY_TEST  = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        sphere_radius;
    } cmd_t;

    typedef struct packed {
        logic reply_kind;
        logic visible;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MA_RD,
        S_MA_CAP,
        S_MA_WR,
        S_NR_RD,
        S_NR_CAP,
        S_NR_MUL,
        S_NR_ACC,
        S_SQRT,
        S_DV_RD,
        S_DV_CAP,
        S_DV_WAIT,
        S_DV_WR,
        S_T_RD,
        S_T_CAP,
        S_T_MUL,
        S_T_ACC,
        S_REPLY
    } state_t;

endpackage

[src/fsc_ram.sv]
// ----------------------------------------------------------------------------
// fsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/fsc_sqrt.sv]
// ----------------------------------------------------------------------------
// fsc_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module fsc_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic        run_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] b_reg;
    logic [64:0] trial;

    assign trial = {1'b0, r_reg} + {1'b0, b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= radicand;
            r_reg <= '0;
            b_reg <= 64'h4000_0000_0000_0000;
        end
        else if (run_reg)
        begin
            if ({1'b0, x_reg} >= trial)
            begin
                x_reg <= x_reg - trial[63:0];
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign root = r_reg[31:0];

endmodule

[src/fsc_div.sv]
// ----------------------------------------------------------------------------
// fsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsc_div #(
    parameter int DW = 49,
    parameter int LW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [LW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          run_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] dvd_reg;
    logic [LW-1:0] dsr_reg;
    logic [LW:0]   rem_reg;
    logic [LW:0]   rem_sh;

    assign rem_sh = {rem_reg[LW-1:0], dvd_reg[DW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
            quotient <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_reg  <= rem_sh - {1'b0, dsr_reg};
                quotient <= {quotient[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                quotient <= {quotient[DW-2:0], 1'b0};
            end
        end
    end

endmodule

[src/frustum_sphere_culler.sv]
// ----------------------------------------------------------------------------
// frustum_sphere_culler
// Frustum plane extraction from a view-projection matrix and sphere culling,
// signed fixed point, state in a matrix RAM and a plane RAM.
// ----------------------------------------------------------------------------
//  channel   signals                  handshake
//  command   start, busy, cmd         taken when start && !busy
//  result    done, result             one-cycle strobe, no backpressure
//
//  Load: busy stays low. Test: 6 planes in turn, then one reply,
//  bound by the single plane RAM read port and the shared multiplier.
//  Build: row sums first, then per plane a length by square root and,
//  when normalized, serial division of the four plane coefficients.
//  Reset clears control state and plane valid bits; no clearing pass.
//  The receiver cannot stall: each result is shown for one cycle.
// ----------------------------------------------------------------------------
`include "frustum_sphere_culler_macros.svh"

module frustum_sphere_culler
    import fsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int PW       = PLANE_COUNT * 4;
    localparam int DW       = 32 + FRAC_BITS + 1;
    localparam int NORM_EPS = ((1 << FRAC_BITS) + 5000) / 10000;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fff_ffff;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    state_t state_reg, state_next;

    logic               accept;
    logic [1:0]         j_reg, r_reg, k_reg;
    logic [2:0]         p_reg;
    logic               last_p;
    logic               kind_reg, vis_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0]        rad_reg;
    logic signed [31:0] row_reg [4];
    logic signed [31:0] mul_a_reg, mul_b_reg;
    logic signed [63:0] mul_p, prod_reg;
    logic [63:0]        sum_reg, sum_tot;
    logic [31:0]        len_reg;
    logic signed [35:0] acc_reg, acc_tot, margin;
    logic signed [31:0] fx_term;
    logic               dv_neg_reg;
    logic [PW-1:0]      pvalid_reg;
    logic [4:0]         prd_addr_reg;

    logic               m_we;
    logic [3:0]         m_raddr;
    logic [31:0]        m_rdata;
    logic               p_we;
    logic [4:0]         p_waddr, p_raddr;
    logic [31:0]        p_wdata, p_rdata;
    logic signed [31:0] pdata;
    logic signed [32:0] row_sum;
    logic [31:0]        pmag;

    logic               sq_start, sq_done;
    logic [31:0]        sq_root;
    logic               dv_start, dv_done;
    logic [DW-1:0]      dv_dividend, dv_q;
    logic signed [31:0] dv_sat;

    assign accept  = start && !busy;
    assign last_p  = (p_reg == 3'(PLANE_COUNT - 1));
    assign mul_p   = mul_a_reg * mul_b_reg;
    assign sum_tot = sum_reg + $unsigned(prod_reg);
    assign pdata   = pvalid_reg[prd_addr_reg] ? $signed(p_rdata) : 32'sd0;
    assign pmag    = pdata[31] ? 32'(-pdata) : 32'(pdata);
    assign fx_term = sat32(prod_reg >>> FRAC_BITS);
    assign acc_tot = acc_reg + 36'(pdata);
    assign margin  = acc_tot + $signed({5'd0, rad_reg});

    always_comb
    begin
        if (p_reg[0])
        begin
            row_sum = 33'(row_reg[3]) - 33'(row_reg[p_reg[2:1]]);
        end
        else
        begin
            row_sum = 33'(row_reg[3]) + 33'(row_reg[p_reg[2:1]]);
        end
    end

    always_comb
    begin
        if (dv_neg_reg)
        begin
            dv_sat = (dv_q > DW'(64'h8000_0000)) ? 32'sh8000_0000 : $signed(-dv_q[31:0]);
        end
        else
        begin
            dv_sat = (dv_q > DW'(64'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(dv_q[31:0]);
        end
    end

    fsc_ram #(.WIDTH(32), .DEPTH(16)) u_matrix_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (cmd.entry_index),
        .wdata (cmd.entry_value),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    fsc_ram #(.WIDTH(32), .DEPTH(PW)) u_plane_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    fsc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_tot),
        .done     (sq_done),
        .root     (sq_root)
    );

    fsc_div #(.DW(DW), .LW(32)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_dividend),
        .divisor  (len_reg),
        .done     (dv_done),
        .quotient (dv_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.action == ACT_BUILD)
                begin
                    state_next = S_MA_RD;
                end
                else if (accept && cmd.action == ACT_TEST)
                begin
                    state_next = S_T_RD;
                end
            end
            S_MA_RD:  state_next = S_MA_CAP;
            S_MA_CAP: state_next = (r_reg == 2'd3) ? S_MA_WR : S_MA_RD;
            S_MA_WR:
            begin
                if (last_p)
                begin
                    state_next = (j_reg == 2'd3) ? S_NR_RD : S_MA_RD;
                end
            end
            S_NR_RD:  state_next = S_NR_CAP;
            S_NR_CAP: state_next = S_NR_MUL;
            S_NR_MUL: state_next = S_NR_ACC;
            S_NR_ACC: state_next = (k_reg == 2'd2) ? S_SQRT : S_NR_RD;
            S_SQRT:
            begin
                if (sq_done)
                begin
                    if (sq_root > 32'(NORM_EPS))
                    begin
                        state_next = S_DV_RD;
                    end
                    else
                    begin
                        state_next = last_p ? S_REPLY : S_NR_RD;
                    end
                end
            end
            S_DV_RD:   state_next = S_DV_CAP;
            S_DV_CAP:  state_next = S_DV_WAIT;
            S_DV_WAIT: state_next = dv_done ? S_DV_WR : S_DV_WAIT;
            S_DV_WR:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = last_p ? S_REPLY : S_NR_RD;
                end
                else
                begin
                    state_next = S_DV_RD;
                end
            end
            S_T_RD: state_next = S_T_CAP;
            S_T_CAP:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = last_p ? S_REPLY : S_T_RD;
                end
                else
                begin
                    state_next = S_T_MUL;
                end
            end
            S_T_MUL: state_next = S_T_ACC;
            S_T_ACC: state_next = S_T_RD;
            S_REPLY: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        busy        = (state_reg != S_IDLE);
        done        = (state_reg == S_REPLY);
        result      = '{reply_kind: kind_reg, visible: vis_reg};
        m_we        = accept && (cmd.action == ACT_LOAD);
        m_raddr     = {j_reg, r_reg};
        p_raddr     = {p_reg, k_reg};
        p_we        = 1'b0;
        p_waddr     = {p_reg, k_reg};
        p_wdata     = dv_sat;
        sq_start    = (state_reg == S_NR_ACC) && (k_reg == 2'd2);
        dv_start    = (state_reg == S_DV_CAP);
        dv_dividend = (DW'(pmag) << FRAC_BITS) + DW'(len_reg >> 1);
        case (state_reg)
            S_MA_WR:
            begin
                p_we    = 1'b1;
                p_waddr = {p_reg, j_reg};
                p_wdata = sat32(64'(row_sum));
            end
            S_DV_WR:
            begin
                p_we = 1'b1;
            end
            default:
            begin
                p_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pvalid_reg   <= '0;
            j_reg        <= '0;
            r_reg        <= '0;
            k_reg        <= '0;
            p_reg        <= '0;
            prd_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            prd_addr_reg <= p_raddr;
            if (p_we)
            begin
                pvalid_reg[p_waddr] <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    j_reg <= '0;
                    r_reg <= '0;
                    k_reg <= '0;
                    p_reg <= '0;
                end
                S_MA_CAP: r_reg <= r_reg + 2'd1;
                S_MA_WR:
                begin
                    if (last_p)
                    begin
                        p_reg <= '0;
                        j_reg <= j_reg + 2'd1;
                        k_reg <= '0;
                    end
                    else
                    begin
                        p_reg <= p_reg + 3'd1;
                    end
                end
                S_NR_ACC: k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                S_SQRT:
                begin
                    if (sq_done && !(sq_root > 32'(NORM_EPS)))
                    begin
                        p_reg <= p_reg + 3'd1;
                    end
                end
                S_DV_WR:
                begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        p_reg <= p_reg + 3'd1;
                    end
                end
                S_T_CAP:
                begin
                    if (k_reg == 2'd3)
                    begin
                        p_reg <= p_reg + 3'd1;
                        k_reg <= '0;
                    end
                end
                S_T_ACC: k_reg <= k_reg + 2'd1;
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_reg <= (cmd.action == ACT_TEST) ? REPLY_TEST : REPLY_BUILT;
                    vis_reg  <= (cmd.action == ACT_TEST);
                    cx_reg   <= cmd.center_x;
                    cy_reg   <= cmd.center_y;
                    cz_reg   <= cmd.center_z;
                    rad_reg  <= cmd.sphere_radius;
                    acc_reg  <= '0;
                    sum_reg  <= '0;
                end
            end
            S_MA_CAP: row_reg[r_reg] <= $signed(m_rdata);
            S_NR_CAP:
            begin
                mul_a_reg <= pdata;
                mul_b_reg <= pdata;
            end
            S_NR_ACC: sum_reg <= (k_reg == 2'd2) ? 64'd0 : sum_tot;
            S_SQRT:
            begin
                if (sq_done)
                begin
                    len_reg <= sq_root;
                end
            end
            S_DV_CAP: dv_neg_reg <= pdata[31];
            S_T_CAP:
            begin
                mul_a_reg <= pdata;
                case (k_reg)
                    2'd0:    mul_b_reg <= cx_reg;
                    2'd1:    mul_b_reg <= cy_reg;
                    default: mul_b_reg <= cz_reg;
                endcase
                if (k_reg == 2'd3)
                begin
                    acc_reg <= '0;
                    if (margin < 0)
                    begin
                        vis_reg <= 1'b0;
                    end
                end
            end
            S_T_ACC: acc_reg <= acc_reg + 36'(fx_term);
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    `FSC_ASSERT_IMP(a_done_busy, done, busy, "result strobe outside a transaction")
    `FSC_ASSERT_NXT(a_done_idle, done, !busy && !done, "result strobe not followed by idle")
    `FSC_ASSERT_NXT(a_build_busy, start && !busy && cmd.action == ACT_BUILD, busy,
                    "build transaction did not raise busy")
    `FSC_ASSERT_IMP(a_load_quiet, start && !busy && cmd.action == ACT_LOAD, !done,
                    "load transaction overlaps a result")

endmodule

[test/tb_frustum_sphere_culler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_sphere_culler
// Self-checking bench for the frustum sphere culler. It loads matrices,
// builds planes and tests spheres with directed and random transactions and
// random gaps. A scoreboard predicts each reply and checks every strobe.
// ----------------------------------------------------------------------------
module tb_frustum_sphere_culler;
    import fsc_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam longint NORM_EPS = ((64'd1 << FRAC_BITS_DEF) + 5000) / 10000;

    class culler_scoreboard;
        logic signed [31:0] mtx [16];
        logic signed [31:0] pln [PLANE_COUNT*4];
        result_t pending [$];
        int errors;

        function new();
            foreach (mtx[i]) mtx[i] = '0;
            foreach (pln[i]) pln[i] = '0;
            errors = 0;
        endfunction

        function logic signed [31:0] sat32(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function longint unsigned isqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint mul_fx(logic signed [31:0] a, logic signed [31:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            return longint'(sat32(p >>> FRAC_BITS_DEF));
        endfunction

        function logic signed [31:0] div_len(logic signed [31:0] v, longint len);
            longint m;
            longint q;
            m = (v < 0) ? -longint'(v) : longint'(v);
            q = ((m << FRAC_BITS_DEF) + len / 2) / len;
            return sat32((v < 0) ? -q : q);
        endfunction

        function void build_planes();
            longint w;
            longint o;
            longint unsigned s;
            longint unsigned m;
            longint len;
            for (int j = 0; j < 4; j++)
            begin
                w = longint'(mtx[j*4+3]);
                for (int p = 0; p < PLANE_COUNT; p++)
                begin
                    o = longint'(mtx[j*4 + ((p >> 1) & 3)]);
                    pln[p*4+j] = sat32((p & 1) ? w - o : w + o);
                end
            end
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                s = 0;
                for (int j = 0; j < 3; j++)
                begin
                    m = (pln[p*4+j] < 0) ? -longint'(pln[p*4+j]) : longint'(pln[p*4+j]);
                    s += m * m;
                end
                len = longint'(isqrt(s));
                if (len > NORM_EPS)
                    for (int j = 0; j < 4; j++)
                        pln[p*4+j] = div_len(pln[p*4+j], len);
            end
        endfunction

        function logic sphere_visible(cmd_t c);
            longint d;
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                d = mul_fx(pln[p*4], c.center_x) + mul_fx(pln[p*4+1], c.center_y)
                    + mul_fx(pln[p*4+2], c.center_z) + longint'(pln[p*4+3]);
                if (d < -longint'({33'd0, c.sphere_radius})) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_cmd(cmd_t c);
            result_t r;
            case (c.action)
                ACT_LOAD: mtx[c.entry_index] = c.entry_value;
                ACT_BUILD:
                begin
                    build_planes();
                    r.reply_kind = REPLY_BUILT;
                    r.visible = 1'b0;
                    pending.push_back(r);
                end
                ACT_TEST:
                begin
                    r.reply_kind = REPLY_TEST;
                    r.visible = sphere_visible(c);
                    pending.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(result_t r);
            result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0b visible=%0b", $realtime,
                         r.reply_kind, r.visible);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.reply_kind !== e.reply_kind)
            begin
                $display("%0t: reply_kind expected %0b actual %0b", $realtime,
                         e.reply_kind, r.reply_kind);
                errors++;
            end
            if (r.visible !== e.visible)
            begin
                $display("%0t: visible expected %0b actual %0b", $realtime,
                         e.visible, r.visible);
                errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    culler_scoreboard sb;

    frustum_sphere_culler uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(result);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    function automatic logic signed [31:0] rand_entry();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return $signed($urandom_range(0, 4 * 65536)) - 32'sd131072;
        if (r < 75) return $signed($urandom_range(0, 16)) - 32'sd8;
        if (r < 85) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        return $urandom;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $signed($urandom_range(0, 8 * 65536)) - 32'sd262144;
        if (r < 88) return $signed($urandom_range(0, 128 * 65536)) - 32'sd4194304;
        return $urandom;
    endfunction

    function automatic logic [30:0] rand_radius();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 31'($urandom_range(0, 2 * 65536));
        if (r < 80) return 31'($urandom_range(0, 1 << 24));
        if (r < 90) return '0;
        return 31'($urandom);
    endfunction

    function automatic cmd_t make_cmd(logic [1:0] act);
        cmd_t c;
        c.action        = act;
        c.entry_index   = 4'($urandom);
        c.entry_value   = rand_entry();
        c.center_x      = rand_coord();
        c.center_y      = rand_coord();
        c.center_z      = rand_coord();
        c.sphere_radius = rand_radius();
        return c;
    endfunction

    task automatic send(input cmd_t c, input bit gaps);
        int n;
        start <= 1'b1;
        cmd <= c;
        while (busy) @(negedge clk);
        @(posedge clk);
        sb.note_cmd(c);
        @(negedge clk);
        n = gaps ? gap_len() : 0;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic load_matrix(input bit identity, input bit gaps);
        cmd_t c;
        for (int i = 0; i < 16; i++)
        begin
            c = make_cmd(ACT_LOAD);
            c.entry_index = 4'(i);
            if (identity) c.entry_value = (i % 5 == 0) ? 32'sh00010000 : '0;
            send(c, gaps);
        end
    endtask

    task automatic send_test(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic [30:0] rad);
        cmd_t c;
        c = make_cmd(ACT_TEST);
        c.center_x = x;
        c.center_y = y;
        c.center_z = z;
        c.sphere_radius = rad;
        send(c, 1'b0);
    endtask

    initial
    begin
        int sent;
        int r;
        int waited;
        cmd_t c;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_test('0, '0, '0, '0);
        load_matrix(1'b1, 1'b0);
        send(make_cmd(ACT_BUILD), 1'b0);
        send_test('0, '0, '0, '0);
        send_test(32'sh00008000, -32'sh00008000, 32'sh00004000, '0);
        send_test(32'sh00030000, '0, '0, '0);
        send_test(32'sh00030000, '0, '0, 31'h00020000);
        send_test(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff);
        send_test(32'sh80000000, 32'sh80000000, 32'sh80000000, '0);
        send_test(32'sh80000000, '0, 32'sh7fffffff, 31'h7fffffff);
        c = make_cmd(ACT_NONE);
        send(c, 1'b0);
        c.action = ACT_LOAD;
        c.entry_index = 4'd3;
        c.entry_value = 32'sh80000000;
        send(c, 1'b0);
        c.entry_index = 4'd0;
        c.entry_value = 32'sh7fffffff;
        send(c, 1'b0);
        send(make_cmd(ACT_BUILD), 1'b0);
        send_test(32'sh00010000, 32'sh80000000, '0, 31'h00001000);

        sent = 0;
        while (sent < 1600)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                load_matrix(1'b0, 1'b1);
                send(make_cmd(ACT_BUILD), 1'b1);
                sent += 17;
            end
            else if (r < 5)
            begin
                send(make_cmd(ACT_BUILD), 1'b1);
                sent++;
            end
            else if (r < 18)
            begin
                send(make_cmd(ACT_LOAD), 1'b1);
                sent++;
            end
            else if (r < 21)
                send(make_cmd(ACT_NONE), 1'b1);
            else
            begin
                send(make_cmd(ACT_TEST), 1'b1);
                sent++;
            end
        end
        start <= 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (100) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[frustum_sphere_culler.f]
+incdir+src
src/fsc_pkg.sv
src/fsc_ram.sv
src/fsc_sqrt.sv
src/fsc_div.sv
src/frustum_sphere_culler.sv
test/tb_frustum_sphere_culler.sv
